[rtl/slcfp_pkg.sv]
// ----------------------------------------------------------------------------
// slcfp_pkg
// Types, constants and register codes shared by the frame parser modules.
// ----------------------------------------------------------------------------
package slcfp_pkg;

  localparam int unsigned DECODED_BYTES = 8;
  localparam int unsigned HEAD_IDX_W    = $clog2(DECODED_BYTES);
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned TDATA_W       = 104;
  localparam int unsigned TUSER_W       = 3;

  localparam logic [7:0]       MAX_PAYLOAD   = 8'd32;
  localparam logic [7:0]       CHECKSUM_BASE = 8'd255;
  localparam logic [8:0]       SUM_MODULUS   = 9'd255;
  localparam logic [LEN_W-1:0] HEAD_LIMIT    = LEN_W'(DECODED_BYTES);

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_NODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WARNING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TIME      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_LENGTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_LENGTH = 3'd7;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_ADDH,
    PH_ADDL,
    PH_KEY,
    PH_LEN,
    PH_DATA,
    PH_CSUM
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NODE,
    KIND_WARNING,
    KIND_TIME,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    logic [7:0]       sync_first;
    logic [7:0]       sync_second;
    logic [LEN_W-1:0] max_payload_length;
    logic [7:0]       key_node_data;
    logic [7:0]       key_warning;
    logic [7:0]       key_time_request;
    logic [LEN_W-1:0] node_data_length;
    logic [LEN_W-1:0] warning_length;
  } cfg_t;

  typedef struct packed {
    logic             checksum_ok;
    kind_t            frame_kind;
    logic [15:0]      src_addr;
    logic [7:0]       frame_key;
    logic [LEN_W-1:0] frame_length;
    logic [31:0]      timestamp;
    logic [7:0]       lamp_on_off;
    logic [7:0]       lamp_dimming;
    logic [15:0]      lamp_current;
    logic [7:0]       fault_code;
  } result_t;

endpackage

[rtl/slcfp_parser.sv]
// ----------------------------------------------------------------------------
// slcfp_parser
// Frame state machine: header capture, payload sum and frame decode.
// ----------------------------------------------------------------------------
module slcfp_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [7:0]                   rx_byte,
  input  slcfp_pkg::cfg_t              cfg,
  output logic                         res_valid,
  output slcfp_pkg::result_t           res
);

  slcfp_pkg::phase_t                phase, phase_next;
  logic [15:0]                      hdr_addr, hdr_addr_next;
  logic [7:0]                       hdr_key, hdr_key_next;
  logic [slcfp_pkg::LEN_W-1:0]      hdr_len, hdr_len_next;
  logic [slcfp_pkg::LEN_W-1:0]      rcv_cnt, rcv_cnt_next;
  logic [7:0]                       sum_mod, sum_mod_next;
  logic [7:0]                       head [slcfp_pkg::DECODED_BYTES];
  logic                             head_we;
  logic [8:0]                       sum_wide;
  logic [slcfp_pkg::LEN_W-1:0]      cnt_inc;
  slcfp_pkg::kind_t                 kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= slcfp_pkg::PH_SYNC1;
      hdr_addr <= '0;
      hdr_key <= '0;
      hdr_len <= '0;
      rcv_cnt <= '0;
      sum_mod <= '0;
    end else if (step) begin
      phase   <= phase_next;
      hdr_addr <= hdr_addr_next;
      hdr_key <= hdr_key_next;
      hdr_len <= hdr_len_next;
      rcv_cnt <= rcv_cnt_next;
      sum_mod <= sum_mod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && head_we) begin
      head[rcv_cnt[slcfp_pkg::HEAD_IDX_W-1:0]] <= rx_byte;
    end
  end

  assign sum_wide = {1'b0, sum_mod} + {1'b0, rx_byte};
  assign cnt_inc  = rcv_cnt + 1'b1;

  always_comb begin
    phase_next    = phase;
    hdr_addr_next = hdr_addr;
    hdr_key_next  = hdr_key;
    hdr_len_next  = hdr_len;
    rcv_cnt_next  = rcv_cnt;
    sum_mod_next  = sum_mod;
    head_we       = 1'b0;
    res_valid     = 1'b0;
    unique case (phase)
      slcfp_pkg::PH_SYNC1: begin
        if (rx_byte == cfg.sync_first) phase_next = slcfp_pkg::PH_SYNC2;
      end
      slcfp_pkg::PH_SYNC2: begin
        phase_next = (rx_byte == cfg.sync_second) ? slcfp_pkg::PH_ADDH
                                                  : slcfp_pkg::PH_SYNC1;
      end
      slcfp_pkg::PH_ADDH: begin
        hdr_addr_next = {rx_byte, 8'h00};
        phase_next    = slcfp_pkg::PH_ADDL;
      end
      slcfp_pkg::PH_ADDL: begin
        hdr_addr_next = {hdr_addr[15:8], rx_byte};
        phase_next    = slcfp_pkg::PH_KEY;
      end
      slcfp_pkg::PH_KEY: begin
        hdr_key_next = rx_byte;
        if (rx_byte == cfg.key_node_data || rx_byte == cfg.key_warning ||
            rx_byte == cfg.key_time_request) begin
          phase_next = slcfp_pkg::PH_LEN;
        end else begin
          phase_next = slcfp_pkg::PH_SYNC1;
        end
      end
      slcfp_pkg::PH_LEN: begin
        sum_mod_next = '0;
        rcv_cnt_next = '0;
        if (rx_byte == 8'd0) begin
          hdr_len_next = '0;
          phase_next   = slcfp_pkg::PH_CSUM;
        end else if (rx_byte > {2'b00, cfg.max_payload_length} ||
                     rx_byte > slcfp_pkg::MAX_PAYLOAD) begin
          phase_next = slcfp_pkg::PH_SYNC1;
        end else begin
          hdr_len_next = rx_byte[slcfp_pkg::LEN_W-1:0];
          phase_next   = slcfp_pkg::PH_DATA;
        end
      end
      slcfp_pkg::PH_DATA: begin
        head_we      = (rcv_cnt < slcfp_pkg::HEAD_LIMIT);
        sum_mod_next = (sum_wide >= slcfp_pkg::SUM_MODULUS) ?
                       8'(sum_wide - slcfp_pkg::SUM_MODULUS) : sum_wide[7:0];
        rcv_cnt_next = cnt_inc;
        if (cnt_inc >= hdr_len) phase_next = slcfp_pkg::PH_CSUM;
      end
      slcfp_pkg::PH_CSUM: begin
        res_valid  = 1'b1;
        phase_next = slcfp_pkg::PH_SYNC1;
      end
      default: phase_next = slcfp_pkg::PH_SYNC1;
    endcase
  end

  always_comb begin
    kind = slcfp_pkg::KIND_OTHER;
    if (hdr_key == cfg.key_node_data) begin
      if (hdr_len == cfg.node_data_length) kind = slcfp_pkg::KIND_NODE;
    end else if (hdr_key == cfg.key_warning) begin
      if (hdr_len == cfg.warning_length) kind = slcfp_pkg::KIND_WARNING;
    end else if (hdr_key == cfg.key_time_request) begin
      kind = slcfp_pkg::KIND_TIME;
    end

    res                = '0;
    res.checksum_ok    = (rx_byte == (slcfp_pkg::CHECKSUM_BASE - sum_mod));
    res.frame_kind     = kind;
    res.src_addr       = hdr_addr;
    res.frame_key      = hdr_key;
    res.frame_length   = hdr_len;
    if (kind == slcfp_pkg::KIND_NODE || kind == slcfp_pkg::KIND_WARNING) begin
      res.timestamp = {head[3], head[2], head[1], head[0]};
    end
    if (kind == slcfp_pkg::KIND_NODE) begin
      res.lamp_on_off  = head[4];
      res.lamp_dimming = head[5];
      res.lamp_current = {head[7], head[6]};
    end
    if (kind == slcfp_pkg::KIND_WARNING) begin
      res.fault_code = head[4];
    end
  end

  a_sum_in_range: assert property (@(posedge clk) disable iff (rst)
    sum_mod != 8'hFF)
    else $error("payload sum left its modulo range");

  a_count_below_length: assert property (@(posedge clk) disable iff (rst)
    phase == slcfp_pkg::PH_DATA |-> rcv_cnt < hdr_len)
    else $error("payload count reached length while still in data phase");

  a_rehunt_after_csum: assert property (@(posedge clk) disable iff (rst)
    step && phase == slcfp_pkg::PH_CSUM |=> phase == slcfp_pkg::PH_SYNC1)
    else $error("parser did not return to hunting after the checksum byte");

  a_node_kind_length: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_kind == slcfp_pkg::KIND_NODE |->
      hdr_len == cfg.node_data_length && hdr_key == cfg.key_node_data)
    else $error("node report decoded with a mismatched key or length");

endmodule

[rtl/sync_length_checksum_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_parser_top
// Byte stream frame parser with sync hunt, length check and checksum.
// ----------------------------------------------------------------------------
// Result path: a checksum byte is held in the input register, and its result
// word is loaded into the output register when the parser steps on it.
// Throughput: one byte per cycle while the output register is empty or being
// read; the parser step sits between the input register and the output register.
// Reset: rst clears the phase, header and sum state and loads the register
// defaults; the payload head bytes hold no reset value.
// ----------------------------------------------------------------------------
module sync_length_checksum_frame_parser_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // src_addr, frame_key, frame_length, timestamp, lamp_on_off,
  // lamp_dimming, lamp_current, fault_code, zero fill
  output logic [slcfp_pkg::TDATA_W-1:0]     m_axis_tdata,
  output logic [slcfp_pkg::TUSER_W-1:0]     m_axis_tuser,  // checksum_ok, frame_kind
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slcfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_data
);

  slcfp_pkg::cfg_t     cfg;
  slcfp_pkg::result_t  res;
  slcfp_pkg::result_t  out_res;
  logic                res_valid;
  logic                in_valid;
  logic [7:0]          in_byte;
  logic                advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first          <= 8'd0;
      cfg.sync_second         <= 8'd0;
      cfg.max_payload_length  <= 6'd32;
      cfg.key_node_data       <= 8'd0;
      cfg.key_warning         <= 8'd1;
      cfg.key_time_request    <= 8'd2;
      cfg.node_data_length    <= 6'd8;
      cfg.warning_length      <= 6'd5;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slcfp_pkg::REG_SYNC_FIRST:     cfg.sync_first          <= cfg_data;
        slcfp_pkg::REG_SYNC_SECOND:    cfg.sync_second         <= cfg_data;
        slcfp_pkg::REG_MAX_LENGTH:     cfg.max_payload_length  <= cfg_data[5:0];
        slcfp_pkg::REG_KEY_NODE:       cfg.key_node_data       <= cfg_data;
        slcfp_pkg::REG_KEY_WARNING:    cfg.key_warning         <= cfg_data;
        slcfp_pkg::REG_KEY_TIME:       cfg.key_time_request    <= cfg_data;
        slcfp_pkg::REG_NODE_LENGTH:    cfg.node_data_length    <= cfg_data[5:0];
        slcfp_pkg::REG_WARNING_LENGTH: cfg.warning_length      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  slcfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tuser = {out_res.frame_kind, out_res.checksum_ok};
  assign m_axis_tdata = {2'b00,
                         out_res.fault_code,
                         out_res.lamp_current,
                         out_res.lamp_dimming,
                         out_res.lamp_on_off,
                         out_res.timestamp,
                         out_res.frame_length,
                         out_res.frame_key,
                         out_res.src_addr};

endmodule
